/* sv/growable_slot_allocator_top_assert.svh */
// ----------------------------------------------------------------------------
// Slot allocator assertion macros
// Property templates shared by the slot allocator's checker.
// ----------------------------------------------------------------------------
`ifndef GROWABLE_SLOT_ALLOCATOR_TOP_ASSERT_SVH
`define GROWABLE_SLOT_ALLOCATOR_TOP_ASSERT_SVH

// The condition must hold in the same cycle as the trigger.
`define GSA_ASSERT_SAME(lbl, trig, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |-> (cond)) \
        else $error("slot allocator check failed");

// The condition must hold in the cycle after the trigger.
`define GSA_ASSERT_NEXT(lbl, trig, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cond)) \
        else $error("slot allocator check failed");

`endif

/* sv/gsa_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot allocator package
// Shared types and codes for the growable slot allocator.
// ----------------------------------------------------------------------------
package gsa_pkg;

    typedef enum logic [2:0] {
        CMD_ALLOC   = 3'd0,
        CMD_RELEASE = 3'd1,
        CMD_QUERY   = 3'd2,
        CMD_CLEAR   = 3'd3,
        CMD_INIT    = 3'd4
    } t_cmd;

    typedef enum logic {
        CFG_SLOT_LIMIT  = 1'b0,
        CFG_START_SLOTS = 1'b1
    } t_cfg_reg;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_state;

    localparam logic [6:0] SLOT_LIMIT_RST  = 7'd64;
    localparam logic [6:0] START_SLOTS_RST = 7'd1;

    typedef struct packed {
        logic [2:0] cmd;
        logic [5:0] slot;
    } t_req;

    typedef struct packed {
        logic       ok;
        logic [5:0] slot_out;
        logic       is_busy;
        logic [6:0] free_count;
        logic       all_busy;
        logic [6:0] pool_size;
    } t_rsp;

    typedef struct packed {
        logic load;
        logic commit;
    } t_ctl;

    typedef struct packed {
        logic out_free;
    } t_sts;

endpackage

/* sv/gsa_req_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot allocator request channel
// Valid/ready channel that carries one command transaction.
// ----------------------------------------------------------------------------
interface gsa_req_if;
    logic          valid;
    logic          ready;
    gsa_pkg::t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* sv/gsa_rsp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot allocator response channel
// Valid/ready channel that carries one result transaction.
// ----------------------------------------------------------------------------
interface gsa_rsp_if;
    logic          valid;
    logic          ready;
    gsa_pkg::t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* sv/gsa_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot allocator controller
// Two-state sequencer: takes a command, then commits it once the output
// register can take the result.
// ----------------------------------------------------------------------------
module gsa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  gsa_pkg::t_sts i_sts,
    output gsa_pkg::t_ctl o_ctl
);
    import gsa_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_req_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_req_ready  = 1'b0;
        o_ctl.load   = 1'b0;
        o_ctl.commit = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_req_ready = 1'b1;
                o_ctl.load  = i_req_valid;
            end
            ST_EXEC: begin
                o_ctl.commit = i_sts.out_free;
            end
            default: begin
                o_req_ready = 1'b0;
            end
        endcase
    end

endmodule

/* sv/gsa_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot allocator datapath
// Busy flags, pool size, free count, configuration, first-free search and
// the result register.
// ----------------------------------------------------------------------------
module gsa_datapath #(
    parameter int MAX_SLOTS = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_cfg_idx,
    input  logic [6:0]    i_cfg_data,
    input  gsa_pkg::t_req i_req_data,
    input  gsa_pkg::t_ctl i_ctl,
    output gsa_pkg::t_sts o_sts,
    output logic          o_rsp_valid,
    input  logic          i_rsp_ready,
    output gsa_pkg::t_rsp o_rsp_data
);
    import gsa_pkg::*;

    localparam int CAP  = (MAX_SLOTS < 127) ? MAX_SLOTS : 127;
    localparam int IW   = (CAP > 1) ? $clog2(CAP) : 1;
    localparam int NGRP = (CAP + 7) / 8;

    logic [CAP-1:0]    r_busy;
    logic [CAP-1:0]    n_busy;
    logic [6:0]        r_pool;
    logic [6:0]        n_pool;
    logic [6:0]        r_fc;
    logic [6:0]        n_fc;
    logic [6:0]        r_limit;
    logic [6:0]        r_start;
    logic [2:0]        r_cmd;
    logic [5:0]        r_slot;
    logic [NGRP-1:0]   r_gany;
    logic [NGRP-1:0]   n_gany;
    logic [2:0]        r_gidx [NGRP];
    logic [2:0]        n_gidx [NGRP];
    logic              r_out_valid;
    t_rsp              r_out;
    t_rsp              n_out;

    logic [CAP-1:0]    w_free_mask;
    logic [NGRP*8-1:0] w_mask_pad;
    logic              w_found;
    logic [6:0]        w_fidx;
    logic [6:0]        w_lim;
    logic [6:0]        w_slot7;
    logic              w_in_range;
    logic [IW-1:0]     w_sidx;

    always_comb begin
        for (int i = 0; i < CAP; i++) begin
            w_free_mask[i] = !r_busy[i] && (7'(i) < r_pool);
        end
        w_mask_pad = (NGRP*8)'(w_free_mask);
    end

    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            n_gany[g] = 1'b0;
            n_gidx[g] = '0;
            for (int b = 7; b >= 0; b--) begin
                if (w_mask_pad[g*8+b]) begin
                    n_gany[g] = 1'b1;
                    n_gidx[g] = 3'(b);
                end
            end
        end
    end

    always_comb begin
        w_found = 1'b0;
        w_fidx  = '0;
        for (int g = NGRP - 1; g >= 0; g--) begin
            if (r_gany[g]) begin
                w_found = 1'b1;
                w_fidx  = 7'(g * 8) + {4'b0000, r_gidx[g]};
            end
        end
    end

    assign w_lim      = (r_limit > 7'(CAP)) ? 7'(CAP) : r_limit;
    assign w_slot7    = {1'b0, r_slot};
    assign w_in_range = (w_slot7 < r_pool) && (w_slot7 < 7'(CAP));
    assign w_sidx     = IW'(w_slot7);

    always_comb begin
        n_busy           = r_busy;
        n_pool           = r_pool;
        n_fc             = r_fc;
        n_out            = '0;
        n_out.slot_out   = r_slot;
        case (t_cmd'(r_cmd))
            CMD_ALLOC: begin
                n_out.slot_out = '0;
                if (w_found) begin
                    n_busy[IW'(w_fidx)] = 1'b1;
                    n_fc                = r_fc - 7'd1;
                    n_out.ok            = 1'b1;
                    n_out.slot_out      = w_fidx[5:0];
                end else if (r_pool < w_lim) begin
                    n_busy[IW'(r_pool)] = 1'b1;
                    n_pool              = r_pool + 7'd1;
                    n_out.ok            = 1'b1;
                    n_out.slot_out      = r_pool[5:0];
                end
            end
            CMD_RELEASE: begin
                if (w_in_range) begin
                    if (r_busy[w_sidx]) begin
                        n_fc = r_fc + 7'd1;
                    end
                    n_busy[w_sidx] = 1'b0;
                    n_out.ok       = 1'b1;
                end
            end
            CMD_QUERY: begin
                if (w_in_range) begin
                    n_out.ok      = 1'b1;
                    n_out.is_busy = r_busy[w_sidx];
                end
            end
            CMD_CLEAR: begin
                n_busy   = '0;
                n_fc     = r_pool;
                n_out.ok = 1'b1;
            end
            CMD_INIT: begin
                n_busy   = '0;
                n_pool   = (r_start > w_lim) ? w_lim : r_start;
                n_fc     = n_pool;
                n_out.ok = 1'b1;
            end
            default: begin
                n_out.ok = 1'b0;
            end
        endcase
        n_out.free_count = n_fc;
        n_out.all_busy   = (n_fc == 7'd0);
        n_out.pool_size  = n_pool;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= '0;
            r_pool      <= '0;
            r_fc        <= '0;
            r_limit     <= SLOT_LIMIT_RST;
            r_start     <= START_SLOTS_RST;
            r_gany      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_gany <= n_gany;
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_SLOT_LIMIT) begin
                    r_limit <= i_cfg_data;
                end else begin
                    r_start <= i_cfg_data;
                end
            end
            if (i_ctl.commit) begin
                r_busy      <= n_busy;
                r_pool      <= n_pool;
                r_fc        <= n_fc;
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_gidx <= n_gidx;
        if (i_ctl.load) begin
            r_cmd  <= i_req_data.cmd;
            r_slot <= i_req_data.slot;
        end
        if (i_ctl.commit) begin
            r_out <= n_out;
        end
    end

    assign o_sts.out_free = !r_out_valid || i_rsp_ready;
    assign o_rsp_valid    = r_out_valid;
    assign o_rsp_data     = r_out;

endmodule

/* sv/growable_slot_allocator_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Growable slot allocator
// Each command transaction is handled in the cycle in which it is accepted
// and then in a commit cycle. In the commit cycle the registered per-group
// free summaries of the busy flags are resolved to the lowest free slot and
// the flags, pool size and free count are updated, and the result is loaded
// into the output register. The commit waits while a previous result is
// still held and not taken; a new command is accepted while a result waits.
// The free count is kept as a running register, so no population count is
// needed. Configuration writes take effect at once and should be made while
// no command is in progress.
// ----------------------------------------------------------------------------
module growable_slot_allocator_top #(
    parameter int MAX_SLOTS = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [6:0] i_cfg_data,
    gsa_req_if.sink    i_req,
    gsa_rsp_if.source  o_rsp
);
    import gsa_pkg::*;

    t_ctl w_ctl;
    t_sts w_sts;

    gsa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_sts       (w_sts),
        .o_ctl       (w_ctl)
    );

    gsa_datapath #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_req_data  (i_req.data),
        .i_ctl       (w_ctl),
        .o_sts       (w_sts),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .o_rsp_data  (o_rsp.data)
    );

endmodule

/* sv/gsa_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot allocator checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "growable_slot_allocator_top_assert.svh"

module gsa_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_rsp_valid,
    input logic          i_rsp_ready,
    input gsa_pkg::t_rsp i_rsp_data
);
    import gsa_pkg::*;

    `GSA_ASSERT_SAME(a_full_flag, i_rsp_valid, i_rsp_data.all_busy == (i_rsp_data.free_count == 7'd0))
    `GSA_ASSERT_SAME(a_free_in_pool, i_rsp_valid, i_rsp_data.free_count <= i_rsp_data.pool_size)
    `GSA_ASSERT_SAME(a_fail_not_busy, i_rsp_valid && !i_rsp_data.ok, !i_rsp_data.is_busy)
    `GSA_ASSERT_NEXT(a_rsp_hold, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(i_rsp_data))

endmodule

bind growable_slot_allocator_top gsa_checker u_gsa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_data  (o_rsp.data)
);

/* tb/sv/growable_slot_allocator_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Growable slot allocator testbench
// Sends allocate, release, query, clear, init and unused command transactions
// under a series of slot limit and start count settings, with random idle
// bursts on both channels. A mirror of the slot pool predicts every response,
// and each response is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module growable_slot_allocator_top_tb;
    import gsa_pkg::*;

    localparam int POOL_CAPACITY = 64;
    localparam int CYCLE_LIMIT   = 300000;

    class slot_pool_mirror;
        bit          busy[POOL_CAPACITY];
        int unsigned pool_cnt;
        logic [6:0]  limit_reg;
        logic [6:0]  start_reg;
        t_rsp        awaited_results[$];
        int unsigned errors;

        function new();
            foreach (busy[i]) busy[i] = 1'b0;
            pool_cnt  = 0;
            limit_reg = SLOT_LIMIT_RST;
            start_reg = START_SLOTS_RST;
            errors    = 0;
        endfunction

        function int unsigned pending();
            return awaited_results.size();
        endfunction

        function int unsigned size_now();
            return pool_cnt;
        endfunction

        function void write_reg(t_cfg_reg idx, logic [6:0] value);
            if (idx == CFG_SLOT_LIMIT) limit_reg = value;
            else start_reg = value;
        endfunction

        function void post_command(t_req req);
            t_rsp        r;
            int unsigned lim;
            int unsigned free_cnt;
            bit          in_range;
            bit          found;
            lim = (limit_reg > POOL_CAPACITY) ? POOL_CAPACITY : limit_reg;
            r = '0;
            r.slot_out = req.slot;
            in_range = (req.slot < pool_cnt);
            found = 1'b0;
            case (req.cmd)
                CMD_ALLOC: begin
                    r.slot_out = '0;
                    for (int i = 0; i < pool_cnt; i++) begin
                        if (!found && !busy[i]) begin
                            busy[i] = 1'b1;
                            r.slot_out = i[5:0];
                            found = 1'b1;
                        end
                    end
                    if (!found && pool_cnt < lim) begin
                        busy[pool_cnt] = 1'b1;
                        r.slot_out = pool_cnt[5:0];
                        pool_cnt++;
                        found = 1'b1;
                    end
                    r.ok = found;
                end
                CMD_RELEASE: begin
                    if (in_range) begin
                        busy[req.slot] = 1'b0;
                        r.ok = 1'b1;
                    end
                end
                CMD_QUERY: begin
                    if (in_range) begin
                        r.is_busy = busy[req.slot];
                        r.ok = 1'b1;
                    end
                end
                CMD_CLEAR: begin
                    foreach (busy[i]) busy[i] = 1'b0;
                    r.ok = 1'b1;
                end
                CMD_INIT: begin
                    foreach (busy[i]) busy[i] = 1'b0;
                    pool_cnt = (start_reg > lim) ? lim : start_reg;
                    r.ok = 1'b1;
                end
                default: begin
                end
            endcase
            free_cnt = 0;
            for (int i = 0; i < pool_cnt; i++) begin
                if (!busy[i]) free_cnt++;
            end
            r.free_count = free_cnt[6:0];
            r.all_busy   = (free_cnt == 0);
            r.pool_size  = pool_cnt[6:0];
            awaited_results.push_back(r);
        endfunction

        function void compare_field(string name, logic [6:0] exp_v, logic [6:0] act_v);
            if (act_v !== exp_v) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_response(t_rsp got);
            t_rsp exp_r;
            if (awaited_results.size() == 0) begin
                $display("%0t: response with none awaited, expected none, actual %p",
                         $time, got);
                errors++;
            end else begin
                exp_r = awaited_results.pop_front();
                compare_field("ok", 7'(exp_r.ok), 7'(got.ok));
                compare_field("slot_out", 7'(exp_r.slot_out), 7'(got.slot_out));
                compare_field("is_busy", 7'(exp_r.is_busy), 7'(got.is_busy));
                compare_field("free_count", exp_r.free_count, got.free_count);
                compare_field("all_busy", 7'(exp_r.all_busy), 7'(got.all_busy));
                compare_field("pool_size", exp_r.pool_size, got.pool_size);
            end
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic       i_cfg_idx;
    logic [6:0] i_cfg_data;
    bit         quiet = 1'b0;
    int         stall_left = 0;
    int         cycle_cnt = 0;

    slot_pool_mirror pool_mirror = new();

    gsa_req_if req_ch ();
    gsa_rsp_if rsp_ch ();

    growable_slot_allocator_top #(
        .MAX_SLOTS (POOL_CAPACITY)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
            stall_left   <= 0;
        end else if (stall_left != 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end else if (!quiet && $urandom_range(0, 4) == 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left   <= $urandom_range(0, 7);
        end else begin
            rsp_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (rsp_ch.valid && rsp_ch.ready) pool_mirror.check_response(rsp_ch.data);
            if (req_ch.valid && req_ch.ready) pool_mirror.post_command(req_ch.data);
        end
    end

    task automatic send_cmd(logic [2:0] cmd, logic [5:0] slot);
        t_req req;
        int   gap;
        req.cmd  = cmd;
        req.slot = slot;
        gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
        if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= req;
        do @(posedge i_clk); while (!req_ch.ready);
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pool_mirror.pending() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic set_pool_config(logic [6:0] lim, logic [6:0] start);
        drain();
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_SLOT_LIMIT;
        i_cfg_data <= lim;
        pool_mirror.write_reg(CFG_SLOT_LIMIT, lim);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_START_SLOTS;
        i_cfg_data <= start;
        pool_mirror.write_reg(CFG_START_SLOTS, start);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic run_random(int count);
        int          pick;
        int unsigned size_cur;
        logic [2:0]  cmd;
        logic [5:0]  slot;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) cmd = CMD_ALLOC;
            else if (pick < 72) cmd = CMD_RELEASE;
            else if (pick < 88) cmd = CMD_QUERY;
            else if (pick < 92) cmd = CMD_CLEAR;
            else if (pick < 96) cmd = CMD_INIT;
            else cmd = 3'($urandom_range(5, 7));
            size_cur = pool_mirror.size_now();
            if ((cmd == CMD_RELEASE || cmd == CMD_QUERY) && size_cur != 0
                    && $urandom_range(0, 4) != 0) begin
                slot = 6'($urandom_range(0, size_cur - 1));
            end else begin
                slot = 6'($urandom_range(0, 63));
            end
            send_cmd(cmd, slot);
        end
    endtask

    initial begin
        logic [6:0] limits[9] = '{7'd127, 7'd5, 7'd0, 7'd64, 7'd1, 7'd33, 7'd127,
                                  7'd0, 7'd0};
        logic [6:0] starts[9] = '{7'd64, 7'd127, 7'd0, 7'd1, 7'd64, 7'd17, 7'd127,
                                  7'd0, 7'd0};
        bit         do_init[9] = '{1, 0, 1, 1, 1, 1, 1, 1, 0};

        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_idx    <= CFG_SLOT_LIMIT;
        i_cfg_data   <= '0;
        req_ch.valid <= 1'b0;
        req_ch.data  <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_cmd(CMD_QUERY, 6'd0);
        send_cmd(CMD_RELEASE, 6'd63);
        send_cmd(CMD_ALLOC, 6'd0);
        send_cmd(CMD_ALLOC, 6'd63);
        send_cmd(CMD_QUERY, 6'd1);
        send_cmd(CMD_RELEASE, 6'd1);
        send_cmd(CMD_QUERY, 6'd1);
        send_cmd(CMD_ALLOC, 6'd0);
        send_cmd(3'd5, 6'd63);
        send_cmd(3'd6, 6'd42);
        send_cmd(3'd7, 6'd0);
        send_cmd(CMD_CLEAR, 6'd21);
        send_cmd(CMD_QUERY, 6'd0);
        send_cmd(CMD_INIT, 6'd0);
        send_cmd(CMD_ALLOC, 6'd0);
        send_cmd(CMD_ALLOC, 6'd0);
        set_pool_config(7'd0, 7'd0);
        send_cmd(CMD_ALLOC, 6'd0);
        send_cmd(CMD_RELEASE, 6'd0);
        send_cmd(CMD_ALLOC, 6'd0);
        send_cmd(CMD_INIT, 6'd0);
        send_cmd(CMD_ALLOC, 6'd0);
        send_cmd(CMD_QUERY, 6'd0);
        set_pool_config(7'd127, 7'd127);
        send_cmd(CMD_INIT, 6'd0);
        send_cmd(CMD_QUERY, 6'd63);
        send_cmd(CMD_RELEASE, 6'd63);
        set_pool_config(7'd2, 7'd64);
        send_cmd(CMD_INIT, 6'd0);

        limits[7] = 7'($urandom_range(0, 127));
        starts[7] = 7'($urandom_range(0, 127));
        limits[8] = 7'($urandom_range(1, 64));
        starts[8] = 7'($urandom_range(1, 64));
        for (int p = 0; p < 9; p++) begin
            set_pool_config(limits[p], starts[p]);
            if (do_init[p]) send_cmd(CMD_INIT, 6'($urandom_range(0, 63)));
            run_random(75);
        end

        set_pool_config(7'd64, 7'd64);
        quiet = 1'b1;
        send_cmd(CMD_INIT, 6'd0);
        run_random(60);

        drain();
        repeat (10) @(posedge i_clk);
        if (pool_mirror.errors == 0 && pool_mirror.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
